/* rtl/core/smru_pkg.sv */
// ----------------------------------------------------------------------------
// smru_pkg
// Shared types and constants for the sorted rowid merge union block.
// ----------------------------------------------------------------------------
package smru_pkg;

    localparam int STREAMS_DEF    = 8;
    localparam int ROWID_BITS_DEF = 64;

    localparam int KIND_W      = 2;
    localparam int STREAM_ID_W = 3;
    localparam int ROW_ID_W    = 64;

    localparam int S_IDX_LSB = 0;
    localparam int S_ROW_LSB = S_IDX_LSB + STREAM_ID_W;
    localparam int S_EXH_BIT = S_ROW_LSB + ROW_ID_W;
    localparam int S_TDATA_W = ((S_EXH_BIT + 1 + 7) / 8) * 8;

    localparam int M_ROW_LSB = 0;
    localparam int M_SRC_LSB = M_ROW_LSB + ROW_ID_W;
    localparam int M_DUP_BIT = M_SRC_LSB + STREAM_ID_W;
    localparam int M_TDATA_W = ((M_DUP_BIT + 1 + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_POP   = 2'd2
    } kind_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                   clear;
        logic                   load;
        logic                   exhausted;
        logic [STREAM_ID_W-1:0] stream_index;
        logic                   consume;
    } cell_ctl_t;

endpackage

/* rtl/core/sorted_rowid_merge_union_top.sv */
// ----------------------------------------------------------------------------
// sorted_rowid_merge_union_top
// Merges up to STREAMS ascending rowid streams into one ascending union.
// ----------------------------------------------------------------------------
// Clear and load words act on the head cells directly. A pop word occupies the
// block while the smallest head is found by a search that
// moves one cell per cycle down the chain of STREAMS head cells, and the
// result is then held in the output register until it is taken. A word of any
// kind is accepted only while that register is free or being taken. Each
// result flags duplicates of the previous rowid and reports end of union on
// m_tuser.
module sorted_rowid_merge_union_top #(
    parameter int STREAMS    = smru_pkg::STREAMS_DEF,
    parameter int ROWID_BITS = smru_pkg::ROWID_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // stream_index, row_id, exhausted, zero padding
    input  logic [smru_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [smru_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // merged_row_id, source_stream, is_duplicate, zero padding
    output logic [smru_pkg::M_TDATA_W-1:0] m_tdata,
    // all_empty
    output logic                           m_tuser
);

    localparam int IDX_W = $clog2(STREAMS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [ROWID_BITS-1:0]   last_reg;
    logic                    have_last_reg;
    logic                    m_valid_reg;
    logic [smru_pkg::ROW_ID_W-1:0]    row_reg;
    logic [smru_pkg::STREAM_ID_W-1:0] src_reg;
    logic                    dup_reg;
    logic                    empty_reg;

    smru_pkg::cell_ctl_t     ctl;
    smru_pkg::kind_t         kind;
    logic                    accept;
    logic                    finish;
    logic                    min_found;
    logic [IDX_W-1:0]        min_idx;
    logic [ROWID_BITS-1:0]   min_val;

    assign kind     = smru_pkg::kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_SCAN) && (cnt_reg == '0);

    always_comb begin
        ctl              = '0;
        ctl.exhausted    = s_tdata[smru_pkg::S_EXH_BIT];
        ctl.stream_index = s_tdata[smru_pkg::S_IDX_LSB +: smru_pkg::STREAM_ID_W];
        ctl.consume      = finish && min_found;
        if (accept) begin
            case (kind)
                smru_pkg::KIND_CLEAR: begin
                    ctl.clear = 1'b1;
                end
                smru_pkg::KIND_LOAD: begin
                    ctl.load = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (kind == smru_pkg::KIND_POP)) begin
                    state_next = ST_SCAN;
                    cnt_next   = IDX_W'(STREAMS - 1);
                end
            end
            ST_SCAN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    smru_chain #(
        .STREAMS    (STREAMS),
        .ROWID_BITS (ROWID_BITS),
        .IDX_W      (IDX_W)
    ) u_chain (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .load_row    (s_tdata[smru_pkg::S_ROW_LSB +: ROWID_BITS]),
        .consume_idx (min_idx),
        .min_found   (min_found),
        .min_idx     (min_idx),
        .min_val     (min_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            have_last_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (ctl.clear) begin
                have_last_reg <= 1'b0;
            end else if (ctl.consume) begin
                have_last_reg <= 1'b1;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.consume) begin
            last_reg <= min_val;
        end
        if (finish) begin
            row_reg   <= min_found ? smru_pkg::ROW_ID_W'(min_val) : '0;
            src_reg   <= min_found ? smru_pkg::STREAM_ID_W'(min_idx) : '0;
            dup_reg   <= min_found && have_last_reg && (min_val == last_reg);
            empty_reg <= !min_found;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[smru_pkg::M_ROW_LSB +: smru_pkg::ROW_ID_W]    = row_reg;
        m_tdata[smru_pkg::M_SRC_LSB +: smru_pkg::STREAM_ID_W] = src_reg;
        m_tdata[smru_pkg::M_DUP_BIT]                          = dup_reg;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = empty_reg;

endmodule

/* rtl/core/smru_cell.sv */
// ----------------------------------------------------------------------------
// smru_cell
// One stream head with its valid mark, plus one stage of the minimum search
// that passes the smallest head seen so far to the next cell.
// ----------------------------------------------------------------------------
module smru_cell #(
    parameter int ROWID_BITS = smru_pkg::ROWID_BITS_DEF,
    parameter int IDX_W      = 3,
    parameter int CELL_IDX   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smru_pkg::cell_ctl_t   ctl,
    input  logic [ROWID_BITS-1:0] load_row,
    input  logic [IDX_W-1:0]      consume_idx,
    input  logic                  found_in,
    input  logic [IDX_W-1:0]      idx_in,
    input  logic [ROWID_BITS-1:0] val_in,
    output logic                  found_out,
    output logic [IDX_W-1:0]      idx_out,
    output logic [ROWID_BITS-1:0] val_out
);

    logic [ROWID_BITS-1:0] head_reg;
    logic                  valid_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ROWID_BITS-1:0] val_reg;
    logic                  load_hit;
    logic                  consume_hit;
    logic                  take;

    assign load_hit    = ctl.load && (int'(ctl.stream_index) == CELL_IDX);
    assign consume_hit = ctl.consume && (consume_idx == IDX_W'(CELL_IDX));
    assign take        = valid_reg && (!found_in || (head_reg < val_in));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (ctl.clear || consume_hit) begin
                valid_reg <= 1'b0;
            end else if (load_hit) begin
                valid_reg <= !ctl.exhausted;
            end
            found_reg <= found_in || valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hit && !ctl.exhausted) begin
            head_reg <= load_row;
        end
        if (take) begin
            idx_reg <= IDX_W'(CELL_IDX);
            val_reg <= head_reg;
        end else begin
            idx_reg <= idx_in;
            val_reg <= val_in;
        end
    end

    assign found_out = found_reg;
    assign idx_out   = idx_reg;
    assign val_out   = val_reg;

endmodule

/* rtl/core/smru_chain.sv */
// ----------------------------------------------------------------------------
// smru_chain
// The row of head cells. The search result leaves the last cell and is
// settled once it has passed each cell's register after the heads stop changing.
// ----------------------------------------------------------------------------
module smru_chain #(
    parameter int STREAMS    = smru_pkg::STREAMS_DEF,
    parameter int ROWID_BITS = smru_pkg::ROWID_BITS_DEF,
    parameter int IDX_W      = $clog2(STREAMS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smru_pkg::cell_ctl_t   ctl,
    input  logic [ROWID_BITS-1:0] load_row,
    input  logic [IDX_W-1:0]      consume_idx,
    output logic                  min_found,
    output logic [IDX_W-1:0]      min_idx,
    output logic [ROWID_BITS-1:0] min_val
);

    logic                  found_w [STREAMS+1];
    logic [IDX_W-1:0]      idx_w   [STREAMS+1];
    logic [ROWID_BITS-1:0] val_w   [STREAMS+1];

    assign found_w[0] = 1'b0;
    assign idx_w[0]   = '0;
    assign val_w[0]   = '0;

    for (genvar i = 0; i < STREAMS; i++) begin : g_cell
        smru_cell #(
            .ROWID_BITS (ROWID_BITS),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .load_row    (load_row),
            .consume_idx (consume_idx),
            .found_in    (found_w[i]),
            .idx_in      (idx_w[i]),
            .val_in      (val_w[i]),
            .found_out   (found_w[i+1]),
            .idx_out     (idx_w[i+1]),
            .val_out     (val_w[i+1])
        );
    end

    assign min_found = found_w[STREAMS];
    assign min_idx   = idx_w[STREAMS];
    assign min_val   = val_w[STREAMS];

endmodule

/* rtl/core/smru_checker.sv */
// ----------------------------------------------------------------------------
// smru_checker
// Port-level checks on the merge union block, bound to its top level.
// ----------------------------------------------------------------------------
module smru_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [smru_pkg::KIND_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [smru_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    logic pop_acc;

    assign pop_acc = s_tvalid && s_tready && (s_tuser == smru_pkg::KIND_POP);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // The block is busy searching in the cycle after a pop is taken.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_acc |=> !s_tready)
        else $error("input accepted during a search");

    // An empty result carries no rowid, stream or duplicate flag.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty result with non-zero data");

    // A new result follows a cycle in which input was held off.
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a search");

endmodule

bind sorted_rowid_merge_union_top smru_checker u_smru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
